[hw/rtl/stbs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared types and constants for the sorted-table binary search block.
// ----------------------------------------------------------------------------
package stbs_pkg;

	localparam int WORD_W     = 40;
	localparam int IDX_W      = 12;
	localparam int CNT_IN_W   = 13;
	localparam int PNUM_W     = 4;
	localparam int MAX_PROBES = 13;

	typedef enum logic {
		OP_LOAD   = 1'b0,
		OP_SEARCH = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		REL_BELOW = 2'd0,
		REL_EQUAL = 2'd1,
		REL_ABOVE = 2'd2,
		REL_EMPTY = 2'd3
	} rel_t;

	typedef enum logic {
		ST_IDLE,
		ST_SEARCH
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;   // write one table entry
		logic start;  // latch key, set bounds, issue first read
		logic emit;   // load output register with current probe, advance
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic done;   // current probe is the final one of the run
	} sts_t;

endpackage

[hw/rtl/stbs_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbs_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module stbs_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[hw/rtl/stbs_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbs_ctrl
// Control state machine: input handshake, search sequencing, output valid.
// ----------------------------------------------------------------------------
module stbs_ctrl
	import stbs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic opcode,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		accept    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				accept    = in_valid;
				cmd.load  = accept && (opcode == OP_LOAD);
				cmd.start = accept && (opcode == OP_SEARCH);
				if (cmd.start) begin
					state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				// advance only when the output register is free or draining
				cmd.emit = !out_valid_q || out_ready;
				if (cmd.emit && sts.done) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

[hw/rtl/stbs_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbs_dp
// Datapath: key table, search bounds, probe compare and output register.
// ----------------------------------------------------------------------------
module stbs_dp
	import stbs_pkg::*;
#(
	parameter int TABLE_DEPTH = 4096,
	parameter int KEY_CHARS   = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	output sts_t                sts,
	input  logic                cfg_wr_en,
	input  logic [CNT_IN_W-1:0] cfg_wr_data,
	input  logic [IDX_W-1:0]    load_index,
	input  logic [WORD_W-1:0]   word,
	output logic [PNUM_W-1:0]   probe_number,
	output logic [IDX_W-1:0]    probe_index,
	output logic [WORD_W-1:0]   probe_word,
	output logic [1:0]          relation,
	output logic                last
);

	localparam int AW       = $clog2(TABLE_DEPTH);
	localparam int CW       = $clog2(TABLE_DEPTH + 1);
	localparam int EW       = (CW > CNT_IN_W) ? CW : CNT_IN_W;
	localparam int IW       = ((AW > IDX_W) ? AW : IDX_W) + 1;
	localparam int KEY_BITS = KEY_CHARS * 8;
	localparam logic [WORD_W-1:0] KEY_MASK = (KEY_BITS >= WORD_W) ? {WORD_W{1'b1}} :
		WORD_W'((65'd1 << KEY_BITS) - 65'd1);
	localparam logic [EW-1:0] DEPTH_E = EW'(TABLE_DEPTH);
	localparam logic [IW-1:0] DEPTH_I = IW'(TABLE_DEPTH);
	localparam logic [PNUM_W-1:0] LAST_PNUM = PNUM_W'(MAX_PROBES - 1);

	function automatic logic [AW-1:0] mid_of(input logic [CW-1:0] lo,
	                                         input logic [CW-1:0] hp1);
		logic [CW:0] s;
		s = {1'b0, lo} + {1'b0, hp1} - (CW+1)'(1);
		return s[AW:1];
	endfunction

	logic [CNT_IN_W-1:0] entry_count_q;
	logic [WORD_W-1:0]   key_q;
	logic [CW-1:0]       low_q, hp1_q;
	logic [AW-1:0]       mid_q;
	logic [PNUM_W-1:0]   pnum_q;
	logic                empty_q;

	logic [EW-1:0]       cnt_e, clip_e;
	logic [CW-1:0]       count_c;
	logic [IW-1:0]       li_w, mid_w;
	logic                ram_we, ram_re;
	logic [AW-1:0]       raddr;
	logic [WORD_W-1:0]   rd_word;
	logic                eq, gt;
	rel_t                rel_c;
	logic [CW-1:0]       nxt_low, nxt_hp1;
	logic [PNUM_W-1:0]   pnum_nxt;
	logic                done_c;

	// clamp the configured count to the table depth
	assign cnt_e   = EW'(entry_count_q);
	assign clip_e  = (cnt_e > DEPTH_E) ? DEPTH_E : cnt_e;
	assign count_c = clip_e[CW-1:0];

	assign li_w   = IW'(load_index);
	assign ram_we = cmd.load && (li_w < DEPTH_I);

	// probe compare on the registered read data
	assign eq = (rd_word == key_q);
	assign gt = (rd_word > key_q);

	always_comb begin
		rel_c   = REL_BELOW;
		nxt_low = low_q;
		nxt_hp1 = hp1_q;
		if (eq) begin
			rel_c = REL_EQUAL;
		end else if (gt) begin
			rel_c   = REL_ABOVE;
			nxt_hp1 = CW'(mid_q);
		end else begin
			nxt_low = CW'(mid_q) + CW'(1);
		end
	end

	assign pnum_nxt = pnum_q + PNUM_W'(1);
	assign done_c   = empty_q || eq || (nxt_low >= nxt_hp1) || (pnum_q == LAST_PNUM);
	assign sts.done = done_c;

	// next read address: first midpoint on start, following midpoint on advance
	assign raddr  = cmd.start ? mid_of(CW'(0), count_c) : mid_of(nxt_low, nxt_hp1);
	assign ram_re = cmd.start || cmd.emit;
	assign mid_w  = IW'(mid_q);

	stbs_ram #(
		.WIDTH (WORD_W),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (li_w[AW-1:0]),
		.wdata (word & KEY_MASK),
		.re    (ram_re),
		.raddr (raddr),
		.rdata (rd_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (cfg_wr_en) begin
			entry_count_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			key_q   <= word & KEY_MASK;
			low_q   <= '0;
			hp1_q   <= count_c;
			pnum_q  <= '0;
			empty_q <= (count_c == '0);
			mid_q   <= raddr;
		end else if (cmd.emit) begin
			low_q  <= nxt_low;
			hp1_q  <= nxt_hp1;
			pnum_q <= pnum_nxt;
			mid_q  <= raddr;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			if (empty_q) begin
				probe_number <= PNUM_W'(1);
				probe_index  <= '0;
				probe_word   <= '0;
				relation     <= REL_EMPTY;
				last         <= 1'b1;
			end else begin
				probe_number <= pnum_nxt;
				probe_index  <= mid_w[IDX_W-1:0];
				probe_word   <= rd_word;
				relation     <= rel_c;
				last         <= done_c;
			end
		end
	end

endmodule

[hw/rtl/sorted_table_binary_search_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_table_binary_search_top
// Binary search over a table of packed fixed-length keys, one result per probe.
// ----------------------------------------------------------------------------
//
//  Channel  Signals                         Direction  Payload
//  -------  ------------------------------  ---------  -----------------------------
//  in       in_valid / in_ready             input      opcode, load_index, word
//  out      out_valid / out_ready           output     probe_number, probe_index,
//                                                      probe_word, relation, last
//  cfg      cfg_wr_en                       input      cfg_wr_data (entry_count)
//
//  A load transfer leaves the block idle and ready for the next input.
//  In a search, the accept issues the first table read; then each step compares
//  the registered read data with the key and issues the next midpoint read.
//  The single RAM read port and its registered output set a one-probe-per-
//  cycle pace. Output stalls hold the search in place; the last result may
//  wait in the output register while the next input transfer is taken.
//  Reset clears control state and entry_count; the table has no clearing pass.
//
module sorted_table_binary_search_top
	import stbs_pkg::*;
#(
	parameter int TABLE_DEPTH = 4096,
	parameter int KEY_CHARS   = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [CNT_IN_W-1:0] cfg_wr_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                opcode,
	input  logic [IDX_W-1:0]    load_index,
	input  logic [WORD_W-1:0]   word,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [PNUM_W-1:0]   probe_number,
	output logic [IDX_W-1:0]    probe_index,
	output logic [WORD_W-1:0]   probe_word,
	output logic [1:0]          relation,
	output logic                last
);

	cmd_t cmd;
	sts_t sts;

	// sequencing: handshake, search run, output valid
	stbs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// table, bounds, compare and result register
	stbs_dp #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.KEY_CHARS   (KEY_CHARS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.load_index   (load_index),
		.word         (word),
		.probe_number (probe_number),
		.probe_index  (probe_index),
		.probe_word   (probe_word),
		.relation     (relation),
		.last         (last)
	);

endmodule

[hw/rtl/stbs_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbs_checker
// Port-level checks for the sorted-table binary search block.
// ----------------------------------------------------------------------------
module stbs_checker
	import stbs_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              opcode,
	input logic              out_valid,
	input logic              out_ready,
	input logic [PNUM_W-1:0] probe_number,
	input logic [IDX_W-1:0]  probe_index,
	input logic [WORD_W-1:0] probe_word,
	input logic [1:0]        relation,
	input logic              last
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(probe_word)
			&& $stable(probe_index) && $stable(probe_number) && $stable(last))
		else $error("stalled result changed");

	// a search transfer blocks input until its run ends
	a_search_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (opcode == OP_SEARCH) |=> !in_ready)
		else $error("input taken during a search run");

	// an empty-table result is a single final probe at index zero
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (relation == REL_EMPTY) |->
			last && (probe_number == PNUM_W'(1)) && (probe_index == '0))
		else $error("malformed empty-table result");

	// a match or the probe limit ends the run
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((relation == REL_EQUAL) || (probe_number == PNUM_W'(MAX_PROBES)))
			|-> last)
		else $error("run continued past a match or the probe limit");

endmodule

bind sorted_table_binary_search_top stbs_checker u_stbs_checker (.*);

[tb/sorted_table_binary_search_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_table_binary_search_top_tb
// Self-checking bench for the sorted-table binary search block. A directed
// table covers the empty table, a one-entry table and the word extremes. A
// random part follows: sorted tables of random size are loaded, searched with
// hit, near-miss and noise keys, and every probe is checked field by field
// against a shadow search model kept in this bench. Deep searches over the
// full depth then load only the entries on each probe path.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_top_tb;
	import stbs_pkg::*;

	localparam int DEPTH       = 4096;
	localparam int SETTLE_CYC  = 20;    // settle margin after the shadow queue drains
	localparam int STALL_LIMIT = 5000;  // cycles with no transfer on either side
	localparam int HOLD_CYC    = 300;   // long receiver hold-off
	localparam int RAND_ITEMS  = 90;
	localparam logic [WORD_W-IDX_W-1:0] DEEP_LOW = 28'h800_0000;

	// One expected probe, in the order the block emits them
	typedef struct packed {
		logic [PNUM_W-1:0] num;
		logic [IDX_W-1:0]  idx;
		logic [WORD_W-1:0] w;
		rel_t              rel;
		logic              fin;
	} probe_t;

	// One row of the directed table; a cfg row carries the count in w
	typedef struct {
		bit                is_cfg;
		op_t               op;
		logic [IDX_W-1:0]  idx;
		logic [WORD_W-1:0] w;
		bit                has_exp;
		probe_t            exp_probe;
	} stim_row_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_wr_en;
	logic [CNT_IN_W-1:0] cfg_wr_data;
	logic                in_valid;
	logic                in_ready;
	logic                opcode;
	logic [IDX_W-1:0]    load_index;
	logic [WORD_W-1:0]   word;
	logic                out_valid;
	logic                out_ready;
	logic [PNUM_W-1:0]   probe_number;
	logic [IDX_W-1:0]    probe_index;
	logic [WORD_W-1:0]   probe_word;
	logic [1:0]          relation;
	logic                last;

	// Shadow of the block: table contents, entry count, pending probes
	logic [WORD_W-1:0]   key_store [DEPTH];
	logic [CNT_IN_W-1:0] active_count = '0;
	probe_t              probe_q [$];

	int unsigned errors       = 0;
	int unsigned stall_cycles = 0;
	int unsigned items_sent   = 0;
	int          send_idle_pct = 30;
	int          recv_idle_pct = 55;
	bit          hold_req      = 1'b0;

	sorted_table_binary_search_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.load_index   (load_index),
		.word         (word),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.probe_number (probe_number),
		.probe_index  (probe_index),
		.probe_word   (probe_word),
		.relation     (relation),
		.last         (last)
	);

	always #5 clk = ~clk;

	function automatic probe_t mk_probe(input int num, input int idx,
			input logic [WORD_W-1:0] w, input rel_t rel, input bit fin);
		probe_t p;
		p.num = num[PNUM_W-1:0];
		p.idx = idx[IDX_W-1:0];
		p.w   = w;
		p.rel = rel;
		p.fin = fin;
		return p;
	endfunction

	function automatic stim_row_t mk_row(input bit is_cfg, input op_t op,
			input logic [IDX_W-1:0] idx, input logic [WORD_W-1:0] w,
			input bit has_exp, input probe_t exp_probe);
		stim_row_t r;
		r.is_cfg    = is_cfg;
		r.op        = op;
		r.idx       = idx;
		r.w         = w;
		r.has_exp   = has_exp;
		r.exp_probe = exp_probe;
		return r;
	endfunction

	// Entry value used by the deep searches; ascending with the index
	function automatic logic [WORD_W-1:0] deep_val(input int idx);
		return {idx[IDX_W-1:0], DEEP_LOW};
	endfunction

	// Walk the binary search the block should run and queue one probe per step.
	// Counts above the table depth clamp to the depth; a zero count gives the
	// single empty-table status.
	task automatic expected_probes(input logic [WORD_W-1:0] key);
		int                span;
		int                lo;
		int                hi;
		int                mid;
		int                n;
		logic [WORD_W-1:0] stored;
		rel_t              rel;
		bit                done;
		span = (active_count > DEPTH) ? DEPTH : int'(active_count);
		if (span == 0) begin
			probe_q.push_back(mk_probe(1, 0, '0, REL_EMPTY, 1'b1));
			return;
		end
		lo   = 0;
		hi   = span - 1;
		n    = 0;
		done = 1'b0;
		while (!done) begin
			mid    = (lo + hi) / 2;
			stored = key_store[mid];
			if (stored == key) begin
				rel  = REL_EQUAL;
				done = 1'b1;
			end else if (stored > key) begin
				rel = REL_ABOVE;
				hi  = mid - 1;
			end else begin
				rel = REL_BELOW;
				lo  = mid + 1;
			end
			n++;
			if (lo > hi || n >= MAX_PROBES)
				done = 1'b1;
			probe_q.push_back(mk_probe(n, mid, stored, rel, done));
		end
	endtask

	// Offer one item, hold it until the transfer, then update the shadow.
	// Valid is lowered only when an idle gap is taken, so it never gets two
	// assignments in one step.
	task automatic send_item(input op_t op, input logic [IDX_W-1:0] idx,
			input logic [WORD_W-1:0] w, input bit has_exp, input probe_t exp_probe);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid   <= 1'b1;
		opcode     <= op;
		load_index <= idx;
		word       <= w;
		do @(posedge clk); while (!in_ready);
		items_sent++;
		if (op == OP_LOAD)
			key_store[idx] = w;
		else if (has_exp)
			probe_q.push_back(exp_probe);
		else
			expected_probes(w);
	endtask

	// Drain the block, let a trailing load settle, then write entry_count
	task automatic write_count(input logic [CNT_IN_W-1:0] v);
		in_valid <= 1'b0;
		while (probe_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en    <= 1'b0;
		active_count = v;
	endtask

	// Fill entries 0..fill-1 with an ascending sequence (with the odd
	// duplicate), set the count, then search. Mostly keys taken from the table
	// or one off; the rest are random keys, word extremes and stray loads that
	// may break the ordering.
	task automatic run_phase(input int fill, input logic [CNT_IN_W-1:0] count_val,
			input int n_search, input bit squeeze);
		logic [63:0]       gap;
		logic [63:0]       acc;
		logic [63:0]       r;
		logic [WORD_W-1:0] key;
		int                span;
		int                i;
		int                pick;
		if (fill > 0) begin
			gap = (64'd1 << WORD_W) / (fill + 1);
			acc = {$urandom, $urandom} % gap;
			for (i = 0; i < fill; i++) begin
				if (i > 0 && $urandom_range(15) != 0)
					acc += {$urandom, $urandom} % gap;
				send_item(OP_LOAD, i[IDX_W-1:0], acc[WORD_W-1:0], 1'b0, '0);
			end
		end
		write_count(count_val);
		span = (count_val > DEPTH) ? DEPTH : int'(count_val);
		// receiver goes quiet while searches keep coming, so the block backs up
		if (squeeze)
			hold_req = 1'b1;
		for (i = 0; i < n_search; i++) begin
			if ($urandom_range(7) == 0) begin
				r = {$urandom, $urandom};
				send_item(OP_LOAD, r[WORD_W+IDX_W-1:WORD_W], r[WORD_W-1:0], 1'b0, '0);
			end
			r    = {$urandom, $urandom};
			pick = $urandom_range(7);
			if (span == 0 || pick == 6) begin
				key = r[WORD_W-1:0];
			end else if (pick == 7) begin
				key = r[0] ? '1 : '0;
			end else begin
				key = key_store[$urandom_range(span - 1)];
				if (pick == 4)
					key = key + 1'b1;
				else if (pick == 5)
					key = key - 1'b1;
			end
			send_item(OP_SEARCH, r[WORD_W+IDX_W-1:WORD_W], key, 1'b0, '0);
		end
	endtask

	// Set the count, then for each key walk the search path over deep_val,
	// load just the entries it probes and search. Keys: all ones (longest
	// path), zero, a stored value, and noise.
	task automatic deep_phase(input logic [CNT_IN_W-1:0] count_val,
			input int n_search);
		logic [63:0]       r;
		logic [WORD_W-1:0] key;
		logic [WORD_W-1:0] val;
		int                span;
		int                lo;
		int                hi;
		int                mid;
		int                n;
		int                i;
		bit                found;
		write_count(count_val);
		span = (count_val > DEPTH) ? DEPTH : int'(count_val);
		for (i = 0; i < n_search; i++) begin
			r = {$urandom, $urandom};
			case (i % 4)
				0:       key = '1;
				1:       key = '0;
				2:       key = deep_val($urandom_range(span - 1));
				default: key = r[WORD_W-1:0];
			endcase
			lo    = 0;
			hi    = span - 1;
			n     = 0;
			found = 1'b0;
			while (!found && lo <= hi && n < MAX_PROBES) begin
				mid = (lo + hi) / 2;
				val = deep_val(mid);
				send_item(OP_LOAD, mid[IDX_W-1:0], val, 1'b0, '0);
				n++;
				if (val == key)
					found = 1'b1;
				else if (val > key)
					hi = mid - 1;
				else
					lo = mid + 1;
			end
			send_item(OP_SEARCH, r[WORD_W+IDX_W-1:WORD_W], key, 1'b0, '0);
		end
	endtask

	task automatic cmp_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			errors++;
		end
	endtask

	// Receiver: check each output transfer, then pick the next ready value.
	// A hold request takes ready low for a counted stretch.
	initial begin
		int     hold_left;
		probe_t want;
		hold_left = 0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (probe_q.size() == 0) begin
					$display("%0t ns: unexpected probe, got index %0h word %0h",
						$time, probe_index, probe_word);
					errors++;
				end else begin
					want = probe_q.pop_front();
					cmp_field("probe_number", want.num, probe_number);
					cmp_field("probe_index", want.idx, probe_index);
					cmp_field("probe_word", want.w, probe_word);
					cmp_field("relation", want.rel, relation);
					cmp_field("last", want.fin, last);
				end
			end
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYC;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Watchdog: end the run if neither side moves for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		stim_row_t         rows [$];
		int unsigned       rand_base;
		int unsigned       done_items;
		int                span;
		bit                first;
		logic [WORD_W-1:0] abcde;
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = '0;
		in_valid    = 1'b0;
		opcode      = OP_LOAD;
		load_index  = '0;
		word        = '0;
		abcde       = 40'h41_42_43_44_45;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: empty table after reset, one-entry table on both
		// sides of its key, then a short sorted table checked by prediction.
		rows.push_back(mk_row(0, OP_SEARCH, 12'd0, '0, 1,
			mk_probe(1, 0, '0, REL_EMPTY, 1)));
		rows.push_back(mk_row(0, OP_SEARCH, 12'hFFF, '1, 1,
			mk_probe(1, 0, '0, REL_EMPTY, 1)));
		rows.push_back(mk_row(0, OP_LOAD, 12'hFFF, '1, 0, '0));
		rows.push_back(mk_row(0, OP_LOAD, 12'd0, abcde, 0, '0));
		rows.push_back(mk_row(1, OP_LOAD, 12'd0, 40'd1, 0, '0));
		rows.push_back(mk_row(0, OP_SEARCH, 12'd0, abcde, 1,
			mk_probe(1, 0, abcde, REL_EQUAL, 1)));
		rows.push_back(mk_row(0, OP_SEARCH, 12'd0, '0, 1,
			mk_probe(1, 0, abcde, REL_ABOVE, 1)));
		rows.push_back(mk_row(0, OP_SEARCH, 12'd0, '1, 1,
			mk_probe(1, 0, abcde, REL_BELOW, 1)));
		rows.push_back(mk_row(0, OP_LOAD, 12'd1, 40'h41_42_43_44_46, 0, '0));
		rows.push_back(mk_row(0, OP_LOAD, 12'd2, 40'h5A_5A_5A_5A_5A, 0, '0));
		rows.push_back(mk_row(0, OP_LOAD, 12'd3, 40'h7A_7A_7A_7A_7A, 0, '0));
		rows.push_back(mk_row(0, OP_LOAD, 12'd4, '1, 0, '0));
		rows.push_back(mk_row(1, OP_LOAD, 12'd0, 40'd5, 0, '0));
		rows.push_back(mk_row(0, OP_SEARCH, 12'd0, 40'h41_42_43_44_46, 0, '0));
		rows.push_back(mk_row(0, OP_SEARCH, 12'd0, '0, 0, '0));
		rows.push_back(mk_row(0, OP_SEARCH, 12'd0, '1, 0, '0));
		rows.push_back(mk_row(0, OP_SEARCH, 12'd0, 40'h41_42_43_44_47, 0, '0));
		rows.push_back(mk_row(0, OP_SEARCH, 12'd0, 40'h5A_5A_5A_5A_5A, 0, '0));

		foreach (rows[i]) begin
			if (rows[i].is_cfg)
				write_count(rows[i].w[CNT_IN_W-1:0]);
			else
				send_item(rows[i].op, rows[i].idx, rows[i].w, rows[i].has_exp,
					rows[i].exp_probe);
		end

		// Random phases on small tables; the idle mix changes by thirds
		rand_base = items_sent;
		first     = 1'b1;
		while (items_sent < rand_base + RAND_ITEMS) begin
			done_items = items_sent - rand_base;
			if (done_items >= 2 * RAND_ITEMS / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end else if (done_items >= RAND_ITEMS / 3) begin
				send_idle_pct = 55;
				recv_idle_pct = 30;
			end
			case ($urandom_range(9))
				0:       span = 0;
				1:       span = 1;
				default: span = $urandom_range(16, 2);
			endcase
			run_phase(span, span[CNT_IN_W-1:0], $urandom_range(12, 4), first);
			first = 1'b0;
		end

		// Full depth: deepest searches, then an oversized count that clamps to
		// the depth, then one short of full
		deep_phase(13'd4096, 4);
		deep_phase('1, 2);
		deep_phase(13'd4095, 2);

		// Drain everything, give stray results a chance to show, then report
		in_valid <= 1'b0;
		while (probe_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
		if (errors == 0 && probe_q.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

[sorted_table_binary_search_top.f]
hw/rtl/stbs_pkg.sv
hw/rtl/stbs_ram.sv
hw/rtl/stbs_ctrl.sv
hw/rtl/stbs_dp.sv
hw/rtl/sorted_table_binary_search_top.sv
hw/rtl/stbs_checker.sv
tb/sorted_table_binary_search_top_tb.sv
